FILE: rtl/pin_pulse_timer_and_pwm_ramp_assert.svh
// Assertion macros for the pin pulse timer and ramp block.
// Each macro checks on the rising edge of i_clk and is idle during reset.
`ifndef PIN_PULSE_TIMER_AND_PWM_RAMP_ASSERT_SVH
`define PIN_PULSE_TIMER_AND_PWM_RAMP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppt_pkg.sv
package ppt_pkg;

    // Field widths
    localparam int VALUE_W    = 16;
    localparam int WVAL_W     = 17;
    localparam int PERIOD_W   = 24;
    localparam int DELAY_W    = 24;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Ramp arithmetic: factor = scale + period, product = value * factor going up, value * scale going down
    localparam int RAMP_SCALE = 10000;
    localparam int FACT_W     = PERIOD_W + 1;
    localparam int PROD_W     = VALUE_W + FACT_W;
    // Quotient bits: large enough for the rising step, and the dividend's
    // top part stays below the smallest divisor
    localparam int QUO_W      = 28;
    localparam int CNT_W      = $clog2(QUO_W + 1);

    localparam int TICK_MS    = 10;

    // Item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Pin modes
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIGITAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMER   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ANALOG  = 2'd3;

    // Run directions
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND     = 3'd5;

endpackage

FILE: rtl/ppt_if.sv
// Input item channel: tick or write command
interface ppt_in_if import ppt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [WVAL_W-1:0] write_value;

    modport source (output valid, op, write_value, input ready);
    modport sink   (input valid, op, write_value, output ready);
endinterface

// Result item channel
interface ppt_out_if import ppt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               pin_written;
    logic [VALUE_W-1:0] pin_value;
    logic               error;

    modport source (output valid, pin_written, pin_value, error, input ready);
    modport sink   (input valid, pin_written, pin_value, error, output ready);
endinterface

// Configuration write channel
interface ppt_cfg_if import ppt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ppt_div.sv
module ppt_div import ppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [FACT_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [QUO_W-1:0]  o_quotient
);

    logic [FACT_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [FACT_W:0]   trial;
    logic [FACT_W:0]   divisor_ext;
    logic              fits;
    logic [FACT_W:0]   diff;
    logic [FACT_W-1:0] n_rem;

    // Restoring step: bring in one dividend bit, subtract when it fits
    always_comb begin
        trial       = {r_rem, r_quo[QUO_W-1]};
        divisor_ext = {1'b0, i_divisor};
        fits        = (trial >= divisor_ext);
        diff        = trial - divisor_ext;
        n_rem       = fits ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= FACT_W'(i_dividend[PROD_W-1:QUO_W]);
            r_quo <= i_dividend[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pin_pulse_timer_and_pwm_ramp.sv
// One output pin driven by ticks and write commands. Every accepted item
// gives exactly one result item. A write, or a tick that does not step the
// ramp, is decoded and stored in the output register from the execute state
// once that register is free. A ramp step passes in order through decode,
// the 16 x 25 bit multiplier, loading the divider, the divide state (28
// one-bit restoring steps, then seeing the divider finish) and a final
// state that clamps the result and stores it once the output register is
// free. The input is ready only between items, but a result may still wait
// in the output register while the next item is taken; the result of that
// next item then waits until the output register is free. Configuration
// writes are taken in any cycle and must only be made while the block is
// idle.
module pin_pulse_timer_and_pwm_ramp import ppt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ppt_in_if.sink    i_in,
    ppt_out_if.source o_out,
    ppt_cfg_if.sink   i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // Configuration registers
    logic [MODE_W-1:0]   r_mode;
    logic                r_start_dir;
    logic [PERIOD_W-1:0] r_period;
    logic                r_repeat;
    logic [VALUE_W-1:0]  r_lower;
    logic [VALUE_W-1:0]  r_upper;

    // Pin state
    logic [DIR_W-1:0]    r_dir,   n_dir;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [VALUE_W-1:0]  r_cur,   n_cur;

    // Sequencer and held item
    logic [2:0]               r_state, n_state;
    logic                     r_op;
    logic signed [WVAL_W-1:0] r_wval;

    // Arithmetic path
    logic [FACT_W-1:0] factor;
    logic [FACT_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic [PROD_W-1:0] r_prod;
    logic [FACT_W-1:0] r_divisor;
    logic              div_busy;
    logic [QUO_W-1:0]  div_quo;

    // Output register
    logic               r_out_valid;
    logic               r_out_written;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_err;

    logic               res_written;
    logic               res_err;
    logic               in_acc;
    logic               out_free;
    logic               ramp_step;
    logic               commit;
    logic [DELAY_W-1:0] delay_sub;
    logic               wval_neg;
    logic               wval_nz;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_start_dir <= 1'b0;
            r_period    <= '0;
            r_repeat    <= 1'b0;
            r_lower     <= '0;
            r_upper     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PIN_MODE:        r_mode      <= i_cfg.data[MODE_W-1:0];
                CFG_START_DIRECTION: r_start_dir <= i_cfg.data[0];
                CFG_PERIOD:          r_period    <= i_cfg.data[PERIOD_W-1:0];
                CFG_REPEAT_ENABLE:   r_repeat    <= i_cfg.data[0];
                CFG_LOWER_BOUND:     r_lower     <= i_cfg.data[VALUE_W-1:0];
                CFG_UPPER_BOUND:     r_upper     <= i_cfg.data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // Decide whether this tick is a ramp step for the divider
    assign ramp_step = (r_op == OP_TICK) && (r_mode == MODE_ANALOG)
                       && (r_upper > r_lower) && (r_period != '0)
                       && (r_dir != DIR_NONE);

    assign delay_sub = r_delay - DELAY_W'(TICK_MS);
    assign wval_neg  = r_wval[WVAL_W-1];
    assign wval_nz   = (r_wval != '0);

    // Work out the effect of the held item on the pin
    always_comb begin
        n_dir       = r_dir;
        n_delay     = r_delay;
        n_cur       = r_cur;
        res_written = 1'b0;
        res_err     = 1'b0;
        if (r_state == S_FIN) begin
            // Clamp the ramp result and turn, or stop, at the bounds
            res_written = 1'b1;
            if (r_dir == DIR_UP) begin
                if (div_quo >= QUO_W'(r_upper)) begin
                    n_cur = r_upper;
                    n_dir = DIR_DOWN;
                end else begin
                    n_cur = div_quo[VALUE_W-1:0];
                end
            end else begin
                if (div_quo <= QUO_W'(r_lower)) begin
                    n_cur = r_lower;
                    n_dir = r_repeat ? DIR_UP : DIR_NONE;
                end else begin
                    n_cur = div_quo[VALUE_W-1:0];
                end
            end
        end else if (r_op == OP_WRITE) begin
            case (r_mode)
                MODE_DIGITAL: begin
                    res_written = 1'b1;
                    n_cur       = r_wval[VALUE_W-1:0];
                end
                MODE_TIMER: begin
                    res_written = 1'b1;
                    if (wval_nz) begin
                        n_cur   = VALUE_W'(r_start_dir);
                        n_delay = DELAY_W'(r_period);
                        n_dir   = r_start_dir ? DIR_DOWN : DIR_UP;
                    end else begin
                        n_cur   = VALUE_W'(!r_start_dir);
                        n_delay = '0;
                        n_dir   = DIR_NONE;
                    end
                end
                MODE_ANALOG: begin
                    res_written = 1'b1;
                    if (!wval_neg) begin
                        n_cur   = r_wval[VALUE_W-1:0];
                        n_delay = '0;
                        n_dir   = DIR_NONE;
                    end else begin
                        n_cur   = r_lower;
                        n_delay = DELAY_W'(r_period);
                        n_dir   = DIR_UP;
                    end
                end
                default: res_err = 1'b1;
            endcase
        end else if (r_mode == MODE_TIMER) begin
            // Count the delay down and flip the level when it runs out
            if ((r_dir != DIR_NONE) && (r_delay >= DELAY_W'(TICK_MS))) begin
                n_delay = delay_sub;
                if (delay_sub == '0) begin
                    res_written = 1'b1;
                    n_cur       = (r_dir == DIR_UP) ? VALUE_W'(1) : '0;
                    n_dir       = (r_dir == DIR_UP) ? DIR_DOWN : DIR_UP;
                    if (r_repeat) begin
                        n_delay = DELAY_W'(r_period);
                    end else begin
                        n_delay = '0;
                        n_dir   = DIR_NONE;
                    end
                end
            end
        end
    end

    assign commit = (((r_state == S_EXEC) && !ramp_step) || (r_state == S_FIN)) && out_free;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_EXEC;
            S_EXEC: begin
                if (ramp_step) begin
                    n_state = S_MUL;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV:  if (!div_busy) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= DIR_NONE;
            r_delay <= '0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_dir   <= n_dir;
                r_delay <= n_delay;
                r_cur   <= n_cur;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in.op;
            r_wval <= i_in.write_value;
        end
    end

    // Multiply: value * factor going up, value * scale going down
    assign factor   = FACT_W'(RAMP_SCALE) + FACT_W'(r_period);
    assign mul_b    = (r_dir == DIR_UP) ? factor : FACT_W'(RAMP_SCALE);
    assign mul_prod = PROD_W'(r_cur) * PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod    <= mul_prod;
            r_divisor <= (r_dir == DIR_UP) ? FACT_W'(RAMP_SCALE) : factor;
        end
    end

    ppt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_prod),
        .i_divisor  (r_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_written <= res_written;
            r_out_value   <= res_written ? n_cur : '0;
            r_out_err     <= res_err;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pin_written = r_out_written;
    assign o_out.pin_value   = r_out_value;
    assign o_out.error       = r_out_err;

`include "pin_pulse_timer_and_pwm_ramp_assert.svh"

    `PPT_ASSERT_SAME(a_err_no_drive, o_out.valid && o_out.error, !o_out.pin_written, "error result drove the pin")
    `PPT_ASSERT_SAME(a_idle_zero, o_out.valid && !o_out.pin_written, o_out.pin_value == '0, "undriven result carries a value")
    `PPT_ASSERT_NEXT(a_accept_exec, in_acc, r_state == S_EXEC, "accepted item not decoded")
    `PPT_ASSERT_SAME(a_div_in_div, div_busy, r_state == S_DIV, "divider busy outside divide state")

endmodule

FILE: tb/pin_pulse_timer_and_pwm_ramp_tb.sv
`timescale 1ns / 1ps

module pin_pulse_timer_and_pwm_ramp_tb;
    import ppt_pkg::*;

    localparam int                    ITEM_TARGET   = 1030;
    localparam int                    SETTLE_CYCLES = 40;
    localparam logic [WVAL_W-1:0]     NEG_ONE       = '1;
    localparam logic [CFG_DATA_W-1:0] PERIOD_MAX    = '1;

    // One expected pin drive
    typedef struct packed {
        logic               written;
        logic [VALUE_W-1:0] value;
        logic               err;
    } t_pin_drive;

    // Pin behaviour tracker and store of expected drives
    class pin_drive_scoreboard;
        logic [MODE_W-1:0]   mode       = MODE_NONE;
        logic                start_down = 1'b0;
        logic [PERIOD_W-1:0] period     = '0;
        logic                repeat_on  = 1'b0;
        logic [VALUE_W-1:0]  low_bound  = '0;
        logic [VALUE_W-1:0]  high_bound = '0;
        logic [DIR_W-1:0]    run_dir    = DIR_NONE;
        logic [DELAY_W-1:0]  delay_left = '0;
        logic [VALUE_W-1:0]  level      = '0;
        t_pin_drive          expected_drives[$];
        int unsigned         fail_count = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PIN_MODE:        mode       = data[MODE_W-1:0];
                CFG_START_DIRECTION: start_down = data[0];
                CFG_PERIOD:          period     = data[PERIOD_W-1:0];
                CFG_REPEAT_ENABLE:   repeat_on  = data[0];
                CFG_LOWER_BOUND:     low_bound  = data[VALUE_W-1:0];
                CFG_UPPER_BOUND:     high_bound = data[VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the pin by one accepted item and queue the expected drive
        function void note_item(logic op, logic [WVAL_W-1:0] wval);
            t_pin_drive      drv;
            longint unsigned v;
            longint unsigned factor;
            drv    = '0;
            factor = RAMP_SCALE;
            factor = factor + period;
            if (op == OP_WRITE) begin
                case (mode)
                    MODE_DIGITAL: begin
                        drv.written = 1'b1;
                        level       = wval[VALUE_W-1:0];
                    end
                    MODE_TIMER: begin
                        drv.written = 1'b1;
                        if (wval != '0) begin
                            level      = start_down ? 16'd1 : 16'd0;
                            delay_left = period;
                            run_dir    = start_down ? DIR_DOWN : DIR_UP;
                        end else begin
                            level      = start_down ? 16'd0 : 16'd1;
                            delay_left = '0;
                            run_dir    = DIR_NONE;
                        end
                    end
                    MODE_ANALOG: begin
                        drv.written = 1'b1;
                        if (!wval[WVAL_W-1]) begin
                            level      = wval[VALUE_W-1:0];
                            delay_left = '0;
                            run_dir    = DIR_NONE;
                        end else begin
                            level      = low_bound;
                            delay_left = period;
                            run_dir    = DIR_UP;
                        end
                    end
                    default: drv.err = 1'b1;
                endcase
            end else if (mode == MODE_TIMER) begin
                // Count down; a remainder below one tick stalls the timer
                if (run_dir != DIR_NONE && delay_left >= TICK_MS) begin
                    delay_left = delay_left - TICK_MS;
                    if (delay_left == '0) begin
                        drv.written = 1'b1;
                        level       = (run_dir == DIR_UP) ? 16'd1 : 16'd0;
                        run_dir     = (run_dir == DIR_UP) ? DIR_DOWN : DIR_UP;
                        if (repeat_on) begin
                            delay_left = period;
                        end else begin
                            delay_left = '0;
                            run_dir    = DIR_NONE;
                        end
                    end
                end
            end else if (mode == MODE_ANALOG) begin
                // Step the duty ramp and clamp at the bounds
                if (high_bound > low_bound && period != '0 && run_dir != DIR_NONE) begin
                    v = level;
                    if (run_dir == DIR_UP) begin
                        v = v * factor / RAMP_SCALE;
                        if (v >= high_bound) begin
                            v       = high_bound;
                            run_dir = DIR_DOWN;
                        end
                    end else begin
                        v = v * RAMP_SCALE / factor;
                        if (v <= low_bound) begin
                            v       = low_bound;
                            run_dir = repeat_on ? DIR_UP : DIR_NONE;
                        end
                    end
                    level       = v[VALUE_W-1:0];
                    drv.written = 1'b1;
                end
            end
            if (drv.written) drv.value = level;
            expected_drives.push_back(drv);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            fail_count++;
            $error("%s: expected %0h, got %0h", field, want, got);
        endfunction

        // Compare one result item with the oldest expected drive
        function void check_drive(logic written, logic [VALUE_W-1:0] value, logic err);
            t_pin_drive want;
            if (expected_drives.size() == 0) begin
                fail_count++;
                $error("result item with nothing expected: pin_written %0h pin_value %0h error %0h",
                       written, value, err);
                return;
            end
            want = expected_drives.pop_front();
            if (want.written !== written) flag("pin_written", want.written, written);
            if (want.value !== value) flag("pin_value", want.value, value);
            if (want.err !== err) flag("error", want.err, err);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idling_on = 1'b1;
    int   sent_items = 0;

    pin_drive_scoreboard sb;

    ppt_in_if  in_ch ();
    ppt_out_if out_ch ();
    ppt_cfg_if cfg_ch ();

    pin_pulse_timer_and_pwm_ramp DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Accept result items, with random back-pressure while idling_on is set
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_drive(out_ch.pin_written, out_ch.pin_value, out_ch.error);
            out_ch.ready <= !(idling_on && $urandom_range(99) < 18);
        end
    end

    function automatic logic [WVAL_W-1:0] random_write_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return NEG_ONE;
        if (pick < 15) return '0;
        if (pick < 20) return {1'b0, {VALUE_W{1'b1}}};
        return {1'b0, 16'($urandom_range(65535))};
    endfunction

    // Offer one item, holding valid high across back-to-back items
    task automatic send_item(logic op, logic [WVAL_W-1:0] wval);
        int gap;
        gap = 0;
        while (idling_on && $urandom_range(99) < 18) gap++;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.write_value <= wval;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_item(op, wval);
        sent_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    // Drop the input and wait until every expected drive has come back
    task automatic drain_pin();
        in_ch.valid <= 1'b0;
        while (sb.expected_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Idle the block, then write all six registers
    task automatic configure(logic [MODE_W-1:0] mode, logic dir, logic [CFG_DATA_W-1:0] per,
                             logic rep, logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi);
        drain_pin();
        write_reg(CFG_PIN_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_START_DIRECTION, CFG_DATA_W'(dir));
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_REPEAT_ENABLE, CFG_DATA_W'(rep));
        write_reg(CFG_LOWER_BOUND, CFG_DATA_W'(lo));
        write_reg(CFG_UPPER_BOUND, CFG_DATA_W'(hi));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [MODE_W-1:0]     mode_sel;
        logic                  dir_sel;
        logic                  rep_sel;
        logic [CFG_DATA_W-1:0] per_sel;
        logic [VALUE_W-1:0]    lo_sel;
        logic [VALUE_W-1:0]    hi_sel;
        logic [WVAL_W-1:0]     wv;
        int unsigned           pick;
        int unsigned           span;
        int                    phase_len;
        bit                    noisy;

        sb = new;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_TICK;
        in_ch.write_value <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_PIN_MODE;
        cfg_ch.data       <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Not-writable mode straight out of reset: tick ignored, write flagged
        send_item(OP_TICK, '0);
        send_item(OP_WRITE, 17'd5);

        // Digital: pass writes through, ignore ticks
        configure(MODE_DIGITAL, 1'b0, '0, 1'b0, '0, '0);
        send_item(OP_WRITE, '0);
        send_item(OP_WRITE, 17'd65535);
        send_item(OP_WRITE, NEG_ONE);
        send_item(OP_TICK, '0);

        // Repeating timer starting up, two fires, then stopped by a zero write
        configure(MODE_TIMER, 1'b0, 24'd20, 1'b1, '0, '0);
        send_item(OP_WRITE, 17'd1);
        repeat (4) send_item(OP_TICK, '0);
        send_item(OP_WRITE, '0);

        // One-shot timer starting down with a delay that stalls below one tick
        configure(MODE_TIMER, 1'b1, 24'd15, 1'b0, '0, '0);
        send_item(OP_WRITE, 17'd65535);
        repeat (2) send_item(OP_TICK, '0);

        // Analog: static write, then a ramp up to the top, down to the bottom, idle
        configure(MODE_ANALOG, 1'b0, 24'd10000, 1'b0, 16'd100, 16'd400);
        send_item(OP_WRITE, 17'd300);
        send_item(OP_WRITE, NEG_ONE);
        repeat (5) send_item(OP_TICK, '0);

        // Random phases: mostly started timers or ramps fed with ticks
        while (sent_items < ITEM_TARGET) begin
            idling_on = !(sent_items >= 400 && sent_items < 600);
            pick = $urandom_range(99);
            mode_sel = (pick < 5)  ? MODE_NONE :
                       (pick < 15) ? MODE_DIGITAL :
                       (pick < 55) ? MODE_TIMER : MODE_ANALOG;
            dir_sel = 1'($urandom_range(1));
            rep_sel = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (mode_sel == MODE_ANALOG) begin
                per_sel = (pick < 70) ? 24'($urandom_range(1000, 20000)) :
                          (pick < 80) ? 24'd0 :
                          (pick < 88) ? PERIOD_MAX : 24'($urandom_range(1, 199));
            end else begin
                per_sel = (pick < 70) ? 24'(10 * $urandom_range(12)) :
                          (pick < 85) ? 24'($urandom_range(130)) :
                          (pick < 93) ? PERIOD_MAX : 24'($urandom);
            end
            pick = $urandom_range(99);
            lo_sel = (pick < 10) ? 16'd0 :
                     (pick < 15) ? 16'hFFFF : 16'($urandom_range(1, 3000));
            pick = $urandom_range(99);
            if (pick < 15) begin
                hi_sel = 16'hFFFF;
            end else if (pick < 25) begin
                hi_sel = 16'($urandom_range(lo_sel));
            end else begin
                span   = lo_sel + $urandom_range(1, 20000);
                hi_sel = (span > 65535) ? 16'hFFFF : 16'(span);
            end
            configure(mode_sel, dir_sel, per_sel, rep_sel, lo_sel, hi_sel);

            phase_len = $urandom_range(10, 40);
            noisy     = ($urandom_range(99) < 10);
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(99);
                wv   = random_write_value();
                if (noisy || mode_sel == MODE_NONE || mode_sel == MODE_DIGITAL) begin
                    send_item((pick < 50) ? OP_TICK : OP_WRITE, wv);
                end else if (k == 0 || (pick >= 85 && pick < 92)) begin
                    // Start or restart the timer or ramp
                    if (mode_sel == MODE_ANALOG) wv = NEG_ONE;
                    else if (wv == '0) wv = 17'd1;
                    send_item(OP_WRITE, wv);
                end else if (pick < 85) begin
                    send_item(OP_TICK, wv);
                end else begin
                    send_item(OP_WRITE, wv);
                end
            end
        end

        idling_on = 1'b1;
        drain_pin();
        if (sb.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: pin_pulse_timer_and_pwm_ramp.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_if.sv
rtl/ppt_div.sv
rtl/pin_pulse_timer_and_pwm_ramp.sv
tb/pin_pulse_timer_and_pwm_ramp_tb.sv
